// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the LIFO stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is held.
`define LSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define LSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Types and constants shared by the LIFO stack block.
package lss_pkg;

  localparam int VAL_W  = 32;
  localparam int TOT_W  = 40;
  localparam int POS_W  = 9;
  localparam int DEP_W  = 9;
  localparam int FIDX_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_PEEK,
    S_SRCH
  } state_t;

  // One stack entry: value plus max and min of itself and everything below.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] maxv;
    logic signed [VAL_W-1:0] minv;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [FIDX_W-1:0]       found_index;
    logic [DEP_W-1:0]        entry_depth;
    logic signed [VAL_W-1:0] top_value;
    logic signed [TOT_W-1:0] total;
    logic signed [VAL_W-1:0] largest;
    logic signed [VAL_W-1:0] smallest;
  } out_item_t;

endpackage

// ===== hw/rtl/lss_if.sv =====
// Valid/ready channel interfaces for stack commands and results.
interface lss_in_if import lss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_t                    cmd;
  logic signed [VAL_W-1:0] push_value;
  logic [POS_W-1:0]        peek_position;
  logic signed [VAL_W-1:0] search_key;

  modport source (output valid, cmd, push_value, peek_position, search_key, input ready);
  modport sink   (input valid, cmd, push_value, peek_position, search_key, output ready);
endinterface

interface lss_out_if import lss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] read_value;
  logic                    found;
  logic [FIDX_W-1:0]       found_index;
  logic [DEP_W-1:0]        entry_depth;
  logic signed [VAL_W-1:0] top_value;
  logic signed [TOT_W-1:0] total;
  logic signed [VAL_W-1:0] largest;
  logic signed [VAL_W-1:0] smallest;

  modport source (output valid, status, read_value, found, found_index, entry_depth,
                  top_value, total, largest, smallest, input ready);
  modport sink   (input valid, status, read_value, found, found_index, entry_depth,
                  top_value, total, largest, smallest, output ready);
endinterface

// ===== hw/rtl/lss_mem.sv =====
// Stack entry memory: one write port, one read port, registered read data.
module lss_mem import lss_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lifo_stack_with_stats_unit.sv =====
// Push, errors, a pop that empties the stack and a search of an empty stack: result is
// registered at the transfer. Other pops and peeks: one memory read, then the result register.
// Search: one entry per cycle from the top until a match or the bottom entry, then the result
// register. The next command is accepted once the control is back in idle and the result
// register is free, so output stalls hold it off.
// Synchronous active-low reset clears depth, total, control and result valid, not the memory.
`include "assert_macros.svh"

module lifo_stack_with_stats_unit import lss_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input logic       clk,
  input logic       rst_n,
  lss_in_if.sink    in_ch,
  lss_out_if.source out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DW    = (AW > FIDX_W) ? AW : FIDX_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [TOT_W-1:0] total_r, total_nxt;
  entry_t                  top_r, top_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [AW-1:0]           d_r, d_nxt;
  logic [AW-1:0]           raddr_r, raddr_nxt;
  out_item_t               out_r, res;
  logic                    out_valid_r, out_valid_nxt;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_wr_data, mem_rd_data;

  logic                    slot_free, accept, push_ok, load;
  logic [CNT_W-1:0]        cnt_m1, cnt_m2;
  logic [AW-1:0]           top_idx;
  logic [CW-1:0]           cnt_ext, pos_ext, peek_addr_ext, cnt_nxt_ext;
  logic [DW-1:0]           d_ext;
  logic signed [TOT_W-1:0] push_ext, top_ext;
  logic                    hit, last;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_read;
  logic                    res_found;
  logic [FIDX_W-1:0]       res_fidx;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && slot_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign push_ok      = accept && (in_ch.cmd == CMD_PUSH) && (count_r != FULL_CNT);

  assign cnt_m1        = count_r - ONE_CNT;
  assign cnt_m2        = cnt_m1 - ONE_CNT;
  assign top_idx       = cnt_m1[AW-1:0];
  assign cnt_ext       = CW'(count_r);
  assign pos_ext       = CW'(in_ch.peek_position);
  assign peek_addr_ext = cnt_ext - pos_ext;
  assign d_ext         = DW'(d_r);
  assign push_ext      = {{(TOT_W-VAL_W){in_ch.push_value[VAL_W-1]}}, in_ch.push_value};
  assign top_ext       = {{(TOT_W-VAL_W){top_r.val[VAL_W-1]}}, top_r.val};

  assign hit  = (mem_rd_data.val == key_r);
  assign last = (d_r == top_idx);

  // New top entry for a push: fold in the running max/min of the entry below.
  always_comb begin
    mem_wr_data.val  = in_ch.push_value;
    mem_wr_data.maxv = in_ch.push_value;
    mem_wr_data.minv = in_ch.push_value;
    if (count_r != '0) begin
      if ($signed(top_r.maxv) > $signed(in_ch.push_value)) begin
        mem_wr_data.maxv = top_r.maxv;
      end
      if ($signed(top_r.minv) < $signed(in_ch.push_value)) begin
        mem_wr_data.minv = top_r.minv;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    top_nxt     = top_r;
    key_nxt     = key_r;
    d_nxt       = d_r;
    raddr_nxt   = raddr_r;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = raddr_r;
    load        = 1'b0;
    res_status  = STS_OK;
    res_read    = '0;
    res_found   = 1'b0;
    res_fidx    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (count_r == FULL_CNT) begin
                res_status = STS_FULL;
              end else begin
                mem_wr_en = 1'b1;
                count_nxt = count_r + ONE_CNT;
                total_nxt = total_r + push_ext;
                top_nxt   = mem_wr_data;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_status = STS_EMPTY;
                load       = 1'b1;
              end else begin
                count_nxt = cnt_m1;
                total_nxt = total_r - top_ext;
                if (count_r == ONE_CNT) begin
                  load = 1'b1;
                end else begin
                  // Fetch the entry that becomes the new top.
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = cnt_m2[AW-1:0];
                  state_nxt   = S_POP;
                end
              end
            end
            CMD_PEEK: begin
              if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                res_status = STS_BADPOS;
                load       = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = peek_addr_ext[AW-1:0];
                state_nxt   = S_PEEK;
              end
            end
            CMD_SEARCH: begin
              key_nxt = in_ch.search_key;
              if (count_r == '0) begin
                load = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = top_idx;
                raddr_nxt   = top_idx;
                d_nxt       = '0;
                state_nxt   = S_SRCH;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          top_nxt   = mem_rd_data;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PEEK: begin
        if (slot_free) begin
          res_read  = mem_rd_data.val;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (hit || last) begin
          // Hold here with the read data stable until the result register frees up.
          if (slot_free) begin
            res_found = hit;
            res_fidx  = hit ? d_ext[FIDX_W-1:0] : '0;
            load      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = raddr_r - AW'(1);
          raddr_nxt   = raddr_r - AW'(1);
          d_nxt       = d_r + AW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Statistics reflect the stack after the operation.
  assign cnt_nxt_ext = CW'(count_nxt);

  always_comb begin
    res.status      = res_status;
    res.read_value  = res_read;
    res.found       = res_found;
    res.found_index = res_fidx;
    res.entry_depth = cnt_nxt_ext[DEP_W-1:0];
    if (count_nxt != '0) begin
      res.top_value = top_nxt.val;
      res.total     = total_nxt;
      res.largest   = top_nxt.maxv;
      res.smallest  = top_nxt.minv;
    end else begin
      res.top_value = '0;
      res.total     = '0;
      res.largest   = '0;
      res.smallest  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    key_r   <= key_nxt;
    d_r     <= d_nxt;
    raddr_r <= raddr_nxt;
    if (load) begin
      out_r <= res;
    end
  end

  lss_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.read_value  = out_r.read_value;
  assign out_ch.found       = out_r.found;
  assign out_ch.found_index = out_r.found_index;
  assign out_ch.entry_depth = out_r.entry_depth;
  assign out_ch.top_value   = out_r.top_value;
  assign out_ch.total       = out_r.total;
  assign out_ch.largest     = out_r.largest;
  assign out_ch.smallest    = out_r.smallest;

  `LSS_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "depth over capacity")
  `LSS_ASSERT(a_push_grow, clk, rst_n, push_ok |=> count_r == $past(count_r) + ONE_CNT, "push lost")
  `LSS_ASSERT(a_srch_ptr, clk, rst_n, (state_r == S_SRCH) |-> CNT_W'(d_r) < count_r, "search overrun")
  `LSS_ASSERT(a_pop_nonempty, clk, rst_n, (state_r == S_POP) |-> (count_r != '0), "empty refill")

endmodule
